>>> rtl/core/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg: shared types and constants for the running statistics unit
// Field widths, derived arithmetic widths and the statistics snapshot record.
// ----------------------------------------------------------------------------
`default_nettype none

package rmvs_pkg;

  // Sample and count widths
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;

  // Fixed result widths
  localparam int TOTAL_BITS = 32;
  localparam int MEAN_BITS  = 24;
  localparam int VAR_BITS   = 39;
  localparam int STD_BITS   = 24;
  localparam int FRAC_BITS  = 8;

  // Derived arithmetic widths
  localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int MAG_BITS    = TOTAL_BITS;
  localparam int MDIV_BITS   = MAG_BITS + FRAC_BITS;
  localparam int NUM_BITS    = COUNT_BITS + SQ_BITS;
  localparam int DEN_BITS    = 2 * COUNT_BITS;
  localparam int VDIV_BITS   = NUM_BITS + FRAC_BITS;
  localparam int LO_BITS     = SQ_BITS / 2;
  localparam int HI_BITS     = SQ_BITS - LO_BITS;
  localparam int SQRT_STEPS  = (VAR_BITS + FRAC_BITS + 1) / 2;
  localparam int STEP_BITS   = $clog2(VDIV_BITS + 1);

  // Queue between front and back (depth is a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0]         COUNT_FULL = {COUNT_BITS{1'b1}};

  // Request codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Accumulated statistics after one request
  typedef struct packed {
    logic [COUNT_BITS-1:0]         n;
    logic signed [TOTAL_BITS-1:0]  sum;
    logic [SQ_BITS-1:0]            s2;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic                          ovf;
  } snap_t;

  localparam snap_t STATS_CLEAR = '{
    n:   '0,
    sum: '0,
    s2:  '0,
    lo:  SAMPLE_MAX,
    hi:  SAMPLE_MIN,
    ovf: 1'b0
  };

endpackage

`default_nettype wire

>>> rtl/core/rmvs_front.sv
// ----------------------------------------------------------------------------
// rmvs_front: request intake and accumulators
// Classifies each request (add, clear, add on full count), updates the
// accumulators and pushes a snapshot of them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvs_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   cmd,
  input  wire logic signed [rmvs_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                   q_full,
  output logic                                        push,
  output rmvs_pkg::snap_t                             push_data
);

  rmvs_pkg::snap_t                      stats;
  rmvs_pkg::snap_t                      stats_next;
  logic [rmvs_pkg::SAMPLE_BITS-1:0]     smag;
  logic [2*rmvs_pkg::SAMPLE_BITS-1:0]   sq_term;

  // Hold requests while the queue is full
  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  // Square of the sample magnitude
  assign smag    = sample[rmvs_pkg::SAMPLE_BITS-1] ? rmvs_pkg::SAMPLE_BITS'(-sample)
                                                  : rmvs_pkg::SAMPLE_BITS'(sample);
  assign sq_term = smag * smag;

  // Classify the request and form the updated statistics
  always_comb begin
    stats_next = stats;
    if (cmd == rmvs_pkg::CMD_CLEAR) begin
      stats_next = rmvs_pkg::STATS_CLEAR;
    end else if (stats.n == rmvs_pkg::COUNT_FULL) begin
      stats_next.ovf = 1'b1;
    end else begin
      stats_next.n   = stats.n + 1'b1;
      stats_next.sum = stats.sum + rmvs_pkg::TOTAL_BITS'(sample);
      stats_next.s2  = stats.s2 + rmvs_pkg::SQ_BITS'(sq_term);
      if (sample < stats.lo) begin
        stats_next.lo = sample;
      end
      if (sample > stats.hi) begin
        stats_next.hi = sample;
      end
    end
  end

  assign push_data = stats_next;

  // Advance the accumulators on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= rmvs_pkg::STATS_CLEAR;
    end else if (push) begin
      stats <= stats_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rmvs_queue.sv
// ----------------------------------------------------------------------------
// rmvs_queue: snapshot queue between intake and solver
// Small register FIFO so intake and solver stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvs_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rmvs_pkg::snap_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 avail,
  output rmvs_pkg::snap_t      pop_data
);

  rmvs_pkg::snap_t               entries [rmvs_pkg::QUEUE_DEPTH];
  logic [rmvs_pkg::PTR_BITS-1:0] wr_ptr;
  logic [rmvs_pkg::PTR_BITS-1:0] rd_ptr;
  logic [rmvs_pkg::PTR_BITS:0]   fill;

  assign full     = (fill == (rmvs_pkg::PTR_BITS+1)'(rmvs_pkg::QUEUE_DEPTH));
  assign avail    = (fill != '0);
  assign pop_data = entries[rd_ptr];

  // Store pushed snapshots
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> fill < (rmvs_pkg::PTR_BITS+1)'(rmvs_pkg::QUEUE_DEPTH))
    else $error("queue pushed while full");

endmodule

`default_nettype wire

>>> rtl/core/rmvs_back.sv
// ----------------------------------------------------------------------------
// rmvs_back: statistics solver
// Takes one snapshot at a time and derives mean, variance and standard
// deviation with a restoring divider pair and a digit-by-digit square root.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvs_back (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    avail,
  output logic                                         pop,
  input  wire rmvs_pkg::snap_t                         item,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [rmvs_pkg::COUNT_BITS-1:0]              sample_count,
  output logic signed [rmvs_pkg::TOTAL_BITS-1:0]       total,
  output logic signed [rmvs_pkg::SAMPLE_BITS-1:0]      smallest,
  output logic signed [rmvs_pkg::SAMPLE_BITS-1:0]      largest,
  output logic signed [rmvs_pkg::MEAN_BITS-1:0]        mean_q8,
  output logic [rmvs_pkg::VAR_BITS-1:0]                variance_q8,
  output logic [rmvs_pkg::STD_BITS-1:0]                std_dev_q8,
  output logic                                         has_data,
  output logic                                         variance_valid,
  output logic                                         count_saturated
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MEAN = 9'b000000010,
    S_SQ   = 9'b000000100,
    S_NSLO = 9'b000001000,
    S_NSHI = 9'b000010000,
    S_DIFF = 9'b000100000,
    S_VDIV = 9'b001000000,
    S_SQRT = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                                    state;
  rmvs_pkg::snap_t                           cur;
  logic [rmvs_pkg::STEP_BITS-1:0]            steps;
  logic                                      neg;
  logic [rmvs_pkg::MAG_BITS-1:0]             mag;
  logic [rmvs_pkg::MAG_BITS-1:0]             item_mag;
  logic [rmvs_pkg::COUNT_BITS-1:0]           mrem;
  logic [rmvs_pkg::MDIV_BITS-1:0]            mq;
  logic [2*rmvs_pkg::MAG_BITS-1:0]           sq;
  logic [rmvs_pkg::NUM_BITS-1:0]             ns;
  logic [rmvs_pkg::DEN_BITS-1:0]             den;
  logic [rmvs_pkg::DEN_BITS-1:0]             vrem;
  logic [rmvs_pkg::VDIV_BITS-1:0]            vq;
  logic [2*rmvs_pkg::SQRT_STEPS-1:0]         srad;
  logic [rmvs_pkg::SQRT_STEPS:0]             srem;
  logic [rmvs_pkg::SQRT_STEPS-1:0]           sroot;
  logic [rmvs_pkg::COUNT_BITS:0]             m_trial;
  logic [rmvs_pkg::DEN_BITS:0]               v_trial;
  logic [rmvs_pkg::SQRT_STEPS+2:0]           s_rem;
  logic [rmvs_pkg::SQRT_STEPS+2:0]           s_trial;
  logic [rmvs_pkg::COUNT_BITS+rmvs_pkg::LO_BITS-1:0] pp_lo;
  logic [rmvs_pkg::COUNT_BITS+rmvs_pkg::HI_BITS-1:0] pp_hi;
  logic [rmvs_pkg::MEAN_BITS-1:0]            mean_mag;
  logic                                      load_out;

  assign pop      = (state == S_IDLE) && avail;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  // Magnitude of the incoming sum
  assign item_mag = item.sum[rmvs_pkg::TOTAL_BITS-1] ? rmvs_pkg::MAG_BITS'(-item.sum)
                                                     : rmvs_pkg::MAG_BITS'(item.sum);

  // Trial subtractions for the dividers and the root
  assign m_trial = {mrem, mq[rmvs_pkg::MDIV_BITS-1]};
  assign v_trial = {vrem, vq[rmvs_pkg::VDIV_BITS-1]};
  assign s_rem   = {srem, srad[2*rmvs_pkg::SQRT_STEPS-1 -: 2]};
  assign s_trial = {1'b0, sroot, 2'b01};

  // Partial products of count times sum of squares
  assign pp_lo = cur.n * cur.s2[rmvs_pkg::LO_BITS-1:0];
  assign pp_hi = cur.n * cur.s2[rmvs_pkg::SQ_BITS-1:rmvs_pkg::LO_BITS];

  assign mean_mag = mq[rmvs_pkg::MEAN_BITS-1:0];

  // Sequence one snapshot through the solver
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (avail) begin
            state <= S_MEAN;
            steps <= rmvs_pkg::STEP_BITS'(rmvs_pkg::MDIV_BITS - 1);
          end
        end
        S_MEAN: begin
          if (steps == '0) begin
            state <= (cur.n > rmvs_pkg::COUNT_BITS'(1)) ? S_SQ : S_DONE;
          end else begin
            steps <= steps - 1'b1;
          end
        end
        S_SQ:   state <= S_NSLO;
        S_NSLO: state <= S_NSHI;
        S_NSHI: state <= S_DIFF;
        S_DIFF: begin
          state <= S_VDIV;
          steps <= rmvs_pkg::STEP_BITS'(rmvs_pkg::VDIV_BITS - 1);
        end
        S_VDIV: begin
          if (steps == '0) begin
            state <= S_SQRT;
            steps <= rmvs_pkg::STEP_BITS'(rmvs_pkg::SQRT_STEPS - 1);
          end else begin
            steps <= steps - 1'b1;
          end
        end
        S_SQRT: begin
          if (steps == '0) begin
            state <= S_DONE;
          end else begin
            steps <= steps - 1'b1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: dividers, products and root
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur  <= item;
        neg  <= item.sum[rmvs_pkg::TOTAL_BITS-1];
        mag  <= item_mag;
        mrem <= '0;
        mq   <= {item_mag, {rmvs_pkg::FRAC_BITS{1'b0}}};
        vq   <= '0;
        sroot <= '0;
      end
      S_MEAN: begin
        if (m_trial >= {1'b0, cur.n}) begin
          mrem <= rmvs_pkg::COUNT_BITS'(m_trial - {1'b0, cur.n});
          mq   <= {mq[rmvs_pkg::MDIV_BITS-2:0], 1'b1};
        end else begin
          mrem <= rmvs_pkg::COUNT_BITS'(m_trial);
          mq   <= {mq[rmvs_pkg::MDIV_BITS-2:0], 1'b0};
        end
      end
      S_SQ: begin
        sq <= mag * mag;
      end
      S_NSLO: begin
        ns <= rmvs_pkg::NUM_BITS'(pp_lo);
      end
      S_NSHI: begin
        ns <= ns + rmvs_pkg::NUM_BITS'({pp_hi, {rmvs_pkg::LO_BITS{1'b0}}});
      end
      S_DIFF: begin
        vq   <= {ns - rmvs_pkg::NUM_BITS'(sq), {rmvs_pkg::FRAC_BITS{1'b0}}};
        vrem <= '0;
        den  <= cur.n * (cur.n - 1'b1);
      end
      S_VDIV: begin
        if (v_trial >= {1'b0, den}) begin
          vrem <= rmvs_pkg::DEN_BITS'(v_trial - {1'b0, den});
          vq   <= {vq[rmvs_pkg::VDIV_BITS-2:0], 1'b1};
        end else begin
          vrem <= rmvs_pkg::DEN_BITS'(v_trial);
          vq   <= {vq[rmvs_pkg::VDIV_BITS-2:0], 1'b0};
        end
        if (steps == '0) begin
          srad  <= (2*rmvs_pkg::SQRT_STEPS)'({v_trial >= {1'b0, den} ?
                     {vq[rmvs_pkg::VAR_BITS-2:0], 1'b1} : {vq[rmvs_pkg::VAR_BITS-2:0], 1'b0},
                     {rmvs_pkg::FRAC_BITS{1'b0}}});
          srem  <= '0;
          sroot <= '0;
        end
      end
      S_SQRT: begin
        srad <= {srad[2*rmvs_pkg::SQRT_STEPS-3:0], 2'b00};
        if (s_rem >= s_trial) begin
          srem  <= (rmvs_pkg::SQRT_STEPS+1)'(s_rem - s_trial);
          sroot <= {sroot[rmvs_pkg::SQRT_STEPS-2:0], 1'b1};
        end else begin
          srem  <= (rmvs_pkg::SQRT_STEPS+1)'(s_rem);
          sroot <= {sroot[rmvs_pkg::SQRT_STEPS-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_count    <= cur.n;
      total           <= cur.sum;
      smallest        <= cur.lo;
      largest         <= cur.hi;
      has_data        <= (cur.n != '0);
      variance_valid  <= (cur.n > rmvs_pkg::COUNT_BITS'(1));
      count_saturated <= cur.ovf;
      if (cur.n == '0) begin
        mean_q8 <= '0;
      end else begin
        mean_q8 <= neg ? rmvs_pkg::MEAN_BITS'(-mean_mag) : rmvs_pkg::MEAN_BITS'(mean_mag);
      end
      if (cur.n > rmvs_pkg::COUNT_BITS'(1)) begin
        variance_q8 <= vq[rmvs_pkg::VAR_BITS-1:0];
        std_dev_q8  <= rmvs_pkg::STD_BITS'(sroot);
      end else begin
        variance_q8 <= '0;
        std_dev_q8  <= '0;
      end
    end
  end

  a_vdiv_needs_two: assert property (@(posedge clk) disable iff (rst)
    state == S_VDIV |-> cur.n > rmvs_pkg::COUNT_BITS'(1))
    else $error("variance division entered with fewer than two samples");

  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    load_out && cur.n == '0 |=> mean_q8 == '0 && !has_data)
    else $error("empty statistics reported a nonzero mean");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && state != S_DONE |=> !out_valid)
    else $error("taken result was repeated");

endmodule

`default_nettype wire

>>> rtl/core/running_mean_variance_stats_top.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stats_top: running count, sum, min, max, mean,
// variance and standard deviation of signed samples
//
// Input channel (in_valid / in_stall): one request per handshake, cmd selects
// add sample or clear. Output channel (out_valid / out_stall): exactly one
// result per request, in request order.
// The intake updates the accumulators in the cycle it takes a request and
// hands a snapshot to a two-entry queue; requests are taken back to back
// until the queue fills.
// The solver handles one snapshot at a time, with a 40-step mean divider,
// then, when two or more samples are held, a 72-step variance divider
// and a 24-step square root; it takes the next snapshot only once the
// result has been loaded into the output register.
// When the receiver stalls, the result holds in the output register while
// the solver finishes the next snapshot, then waits for the register to free.
// Reset empties the statistics, the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module running_mean_variance_stats_top (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic                                    cmd,
  input  wire logic signed [rmvs_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic [rmvs_pkg::COUNT_BITS-1:0]              sample_count,
  output logic signed [rmvs_pkg::TOTAL_BITS-1:0]       total,
  output logic signed [rmvs_pkg::SAMPLE_BITS-1:0]      smallest,
  output logic signed [rmvs_pkg::SAMPLE_BITS-1:0]      largest,
  output logic signed [rmvs_pkg::MEAN_BITS-1:0]        mean_q8,
  output logic [rmvs_pkg::VAR_BITS-1:0]                variance_q8,
  output logic [rmvs_pkg::STD_BITS-1:0]                std_dev_q8,
  output logic                                         has_data,
  output logic                                         variance_valid,
  output logic                                         count_saturated
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_avail;
  rmvs_pkg::snap_t q_in;
  rmvs_pkg::snap_t q_out;

  // Intake and accumulators
  rmvs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sample    (sample),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  // Snapshot queue
  rmvs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  // Solver and result register
  rmvs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .avail           (q_avail),
    .pop             (q_pop),
    .item            (q_out),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample_count    (sample_count),
    .total           (total),
    .smallest        (smallest),
    .largest         (largest),
    .mean_q8         (mean_q8),
    .variance_q8     (variance_q8),
    .std_dev_q8      (std_dev_q8),
    .has_data        (has_data),
    .variance_valid  (variance_valid),
    .count_saturated (count_saturated)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: running mean and variance statistics unit
// Drives add and clear requests with random gaps. Each request is applied to
// a local statistics model that computes the expected result record. Results
// are checked in order with random receiver stalls, one long receiver hold
// and one sender pause until all results have drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int HALF_PERIOD = 5;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 400;
  localparam int LONG_HOLD   = 700;

  typedef struct {
    logic                              cmd;
    logic [rmvs_pkg::SAMPLE_BITS-1:0]  sample;
    bit                                drain_first;
  } request_t;

  typedef struct {
    logic [rmvs_pkg::COUNT_BITS-1:0]  count;
    logic [rmvs_pkg::TOTAL_BITS-1:0]  total;
    logic [rmvs_pkg::SAMPLE_BITS-1:0] smallest;
    logic [rmvs_pkg::SAMPLE_BITS-1:0] largest;
    logic [rmvs_pkg::MEAN_BITS-1:0]   mean;
    logic [rmvs_pkg::VAR_BITS-1:0]    variance;
    logic [rmvs_pkg::STD_BITS-1:0]    std_dev;
    logic                             has_data;
    logic                             var_valid;
    logic                             saturated;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = rmvs_pkg::CMD_ADD;
  logic signed [rmvs_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rmvs_pkg::COUNT_BITS-1:0] sample_count;
  logic signed [rmvs_pkg::TOTAL_BITS-1:0] total;
  logic signed [rmvs_pkg::SAMPLE_BITS-1:0] smallest, largest;
  logic signed [rmvs_pkg::MEAN_BITS-1:0] mean_q8;
  logic [rmvs_pkg::VAR_BITS-1:0] variance_q8;
  logic [rmvs_pkg::STD_BITS-1:0] std_dev_q8;
  logic has_data, variance_valid, count_saturated;

  running_mean_variance_stats_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample_count(sample_count), .total(total), .smallest(smallest),
    .largest(largest), .mean_q8(mean_q8), .variance_q8(variance_q8),
    .std_dev_q8(std_dev_q8), .has_data(has_data),
    .variance_valid(variance_valid), .count_saturated(count_saturated)
  );

  always #HALF_PERIOD clk = ~clk;

  // Statistics model state
  logic [63:0]                      mdl_sum;
  logic [63:0]                      mdl_sum_sq;
  logic [rmvs_pkg::COUNT_BITS-1:0]  mdl_count;
  logic [rmvs_pkg::SAMPLE_BITS-1:0] mdl_min;
  logic [rmvs_pkg::SAMPLE_BITS-1:0] mdl_max;
  bit                               mdl_ovf;

  request_t pending_requests[$];
  stats_t   expected_stats[$];
  int       mismatches = 0;
  int       requests_sent = 0;
  int       results_seen = 0;
  int       clears_sent = 0;
  int       idle_cycles = 0;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic clear_model();
    mdl_sum = '0;
    mdl_sum_sq = '0;
    mdl_count = '0;
    mdl_min = rmvs_pkg::SAMPLE_MAX;
    mdl_max = rmvs_pkg::SAMPLE_MIN;
    mdl_ovf = 1'b0;
  endtask

  // Apply one request to the model and queue the resulting statistics
  task automatic apply_request(input request_t req);
    stats_t res;
    logic [63:0] n, mag, q, num, den, vq, smag;
    logic signed [63:0] v;
    bit neg;
    if (req.cmd == rmvs_pkg::CMD_CLEAR) begin
      clear_model();
    end else if (mdl_count == rmvs_pkg::COUNT_FULL) begin
      mdl_ovf = 1'b1;
    end else begin
      v = 64'(signed'(req.sample));
      smag = (v < 0) ? 64'(-v) : 64'(v);
      mdl_sum = mdl_sum + 64'(v);
      mdl_sum_sq = mdl_sum_sq + smag * smag;
      if (signed'(req.sample) > signed'(mdl_max)) mdl_max = req.sample;
      if (signed'(req.sample) < signed'(mdl_min)) mdl_min = req.sample;
      mdl_count = mdl_count + 1'b1;
    end
    n = 64'(mdl_count);
    neg = mdl_sum[63];
    mag = neg ? -mdl_sum : mdl_sum;
    res.mean = '0;
    res.variance = '0;
    res.std_dev = '0;
    if (n >= 1) begin
      q = (mag * 256) / n;
      res.mean = rmvs_pkg::MEAN_BITS'(neg ? -q : q);
    end
    if (n >= 2) begin
      num = n * mdl_sum_sq - mag * mag;
      den = n * (n - 1);
      vq = (num / den) * 256 + ((num % den) * 256) / den;
      res.variance = rmvs_pkg::VAR_BITS'(vq);
      res.std_dev = rmvs_pkg::STD_BITS'(floor_sqrt(64'(res.variance) << 8));
    end
    res.count = mdl_count;
    res.total = rmvs_pkg::TOTAL_BITS'(mdl_sum);
    res.smallest = mdl_min;
    res.largest = mdl_max;
    res.has_data = (n >= 1);
    res.var_valid = (n >= 2);
    res.saturated = mdl_ovf;
    expected_stats.push_back(res);
  endtask

  // Driver: one request per handshake, random gap before each
  int gap_left = 0;
  always @(posedge clk) begin
    request_t nxt;
    logic next_valid;
    bit taken;
    taken = in_valid && !in_stall;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (taken) begin
        apply_request('{cmd, sample, 1'b0});
        requests_sent++;
        if (cmd == rmvs_pkg::CMD_CLEAR) clears_sent++;
        next_valid = 1'b0;
      end
      if (!in_valid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain_first && expected_stats.size() > 0)) begin
          nxt = pending_requests.pop_front();
          cmd <= nxt.cmd;
          sample <= nxt.sample;
          next_valid = 1'b1;
          // no gaps in a quiet stretch of the run
          gap_left = (requests_sent inside {[600:700]}) ? 0 : $urandom_range(4);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Monitor: check each result against the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    stats_t e;
    bit bad;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected, count %0d",
                                       sample_count);
      end else begin
        e = expected_stats.pop_front();
        bad = (sample_count !== e.count) || (total !== e.total) ||
              (smallest !== e.smallest) || (largest !== e.largest) ||
              (mean_q8 !== e.mean) || (variance_q8 !== e.variance) ||
              (std_dev_q8 !== e.std_dev) || (has_data !== e.has_data) ||
              (variance_valid !== e.var_valid) || (count_saturated !== e.saturated);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d expected n=%0d sum=%0d min=%0d max=%0d mean=%0d",
                     results_seen, e.count, signed'(e.total), signed'(e.smallest),
                     signed'(e.largest), signed'(e.mean));
            $display("       var=%0d sd=%0d flags=%b%b%b", e.variance, e.std_dev,
                     e.has_data, e.var_valid, e.saturated);
            $display("       actual n=%0d sum=%0d min=%0d max=%0d mean=%0d", sample_count,
                     total, smallest, largest, mean_q8);
            $display("       var=%0d sd=%0d flags=%b%b%b", variance_q8, std_dev_q8,
                     has_data, variance_valid, count_saturated);
          end
        end
      end
      // one long hold so the queue fills and the intake stalls
      if (results_seen == 300) stall_left = LONG_HOLD;
      else if (results_seen inside {[700:800]}) stall_left = 0;
      else stall_left = $urandom_range(4);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= !rst && (stall_left > 0);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic add_req(input logic c, input logic [rmvs_pkg::SAMPLE_BITS-1:0] s,
                         input bit d = 0);
    request_t r;
    r.cmd = c;
    r.sample = s;
    r.drain_first = d;
    pending_requests.push_back(r);
  endtask

  function automatic logic [rmvs_pkg::SAMPLE_BITS-1:0] random_sample(input int style);
    case (style)
      0: return rmvs_pkg::SAMPLE_MAX;
      1: return rmvs_pkg::SAMPLE_MIN;
      2: return rmvs_pkg::SAMPLE_BITS'($urandom_range(8) - 4);
      3: return rmvs_pkg::SAMPLE_BITS'($urandom_range(2000) - 1000);
      default: return rmvs_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int len, style;
    bit drain_set;
    drain_set = 1'b0;
    clear_model();
    // Directed: empty state, extremes, single sample, clears
    add_req(rmvs_pkg::CMD_CLEAR, '0);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MAX);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MIN);
    add_req(rmvs_pkg::CMD_ADD, '0);
    add_req(rmvs_pkg::CMD_ADD, '1);
    add_req(rmvs_pkg::CMD_ADD, 16'sd1);
    add_req(rmvs_pkg::CMD_CLEAR, 16'h5a5a);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MIN);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MIN);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MIN);
    add_req(rmvs_pkg::CMD_CLEAR, '1);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MAX);
    add_req(rmvs_pkg::CMD_ADD, rmvs_pkg::SAMPLE_MAX);
    add_req(rmvs_pkg::CMD_CLEAR, '0);
    add_req(rmvs_pkg::CMD_ADD, -16'sd7);
    add_req(rmvs_pkg::CMD_ADD, 16'sd3);
    add_req(rmvs_pkg::CMD_ADD, 16'sd2);
    add_req(rmvs_pkg::CMD_CLEAR, '0);
    add_req(rmvs_pkg::CMD_CLEAR, '0);
    // Random: mostly clear then a run of adds, with stray adds mixed in.
    // Count saturation needs a full count of adds and is not reached here.
    while (pending_requests.size() < 1150) begin
      if ($urandom_range(9) == 0) begin
        add_req(rmvs_pkg::CMD_ADD, random_sample($urandom_range(4)));
      end else begin
        // first clear late in the run waits until every result is out
        if (!drain_set && pending_requests.size() > 900) begin
          add_req(rmvs_pkg::CMD_CLEAR, rmvs_pkg::SAMPLE_BITS'($urandom), 1'b1);
          drain_set = 1'b1;
        end else begin
          add_req(rmvs_pkg::CMD_CLEAR, rmvs_pkg::SAMPLE_BITS'($urandom));
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(200, 40) : $urandom_range(12);
        style = $urandom_range(5);
        for (int k = 0; k < len; k++)
          add_req(rmvs_pkg::CMD_ADD, random_sample((style == 5) ? $urandom_range(4) : style));
      end
    end
    if (!drain_set) add_req(rmvs_pkg::CMD_CLEAR, '0, 1'b1);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_requests.size() == 0 && !in_valid && expected_stats.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (expected_stats.size() != 0) mismatches++;
    $display("Covered %0d requests (%0d clears) and checked %0d results, %0d mismatches.",
             requests_sent, clears_sent, results_seen, mismatches);
    $display("Included extreme samples, empty and single-sample states and stall pressure.");
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
